// ===== src/irr_pkg.sv =====
// package: shared constants and types for the bilinear image rotation block
`timescale 1ns / 1ps
`default_nettype none
package irr_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS  = 4;

  localparam int COORD_W = 8;   // pixel_x, pixel_y
  localparam int SIZE_W  = 9;   // image_width, image_height
  localparam int TRIG_W  = 6;   // cos_q4, sin_q4
  localparam int COLOR_W = 8;
  localparam int NUM_CH  = 3;
  localparam int PIXEL_W = NUM_CH * COLOR_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_COS    = 2'd2,
    CFG_SIN    = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_COMPUTE = 1'b1
  } op_t;

endpackage
`default_nettype wire

// ===== src/irr_ifs.sv =====
// interfaces: input, result and configuration channels
`timescale 1ns / 1ps
`default_nettype none
interface irr_in_if
  import irr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [COLOR_W-1:0] in_red;
  logic [COLOR_W-1:0] in_green;
  logic [COLOR_W-1:0] in_blue;

  modport source (output valid, operation, pixel_x, pixel_y, in_red, in_green, in_blue,
                  input ready);
  modport sink (input valid, operation, pixel_x, pixel_y, in_red, in_green, in_blue,
                output ready);
endinterface

interface irr_out_if
  import irr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] dest_x;
  logic [COORD_W-1:0] dest_y;
  logic [COLOR_W-1:0] out_red;
  logic [COLOR_W-1:0] out_green;
  logic [COLOR_W-1:0] out_blue;
  logic               outside;

  modport source (output valid, dest_x, dest_y, out_red, out_green, out_blue, outside,
                  input ready);
  modport sink (input valid, dest_x, dest_y, out_red, out_green, out_blue, outside,
                output ready);
endinterface

interface irr_cfg_if
  import irr_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/irr_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module irr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== src/image_rotate_bilinear_q4.sv =====
// top level: rotation mapping, banked image store and bilinear blend pipeline
`timescale 1ns / 1ps
`default_nettype none
// Rotates an image about its centre with bilinear blending. A write word (operation 0)
// stores one RGB source pixel; a compute word (operation 1) names a destination pixel
// and yields one result: the blend of the four source neighbours, or black with
// outside set. The pipeline takes one word per clock while the output is not
// stalled, and holds six register stages (input, products, sums, store address,
// pixel weighting, output). The store is split into four banks by x and y parity,
// one read port each, so all four neighbours are read in the same cycle; writes go
// through the same stage as reads, which keeps store order equal to word order. A
// stalled output freezes the whole pipeline. Configuration may be written
// only while no word is in flight.
module image_rotate_bilinear_q4
  import irr_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input wire logic clk,
  input wire logic rst_n,
  irr_in_if.sink     in_ch,
  irr_out_if.source  out_ch,
  irr_cfg_if.sink    cfg_ch
);

  localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int CW         = SIZE_W;                  // source coordinate width
  localparam int DW         = CW + 1;                  // signed offset from centre
  localparam int PRW        = DW + TRIG_W;             // offset times trig
  localparam int SW         = 17 + FRAC_BITS;          // fixed-point source position
  localparam int IW         = SW - FRAC_BITS;          // integer part of position
  localparam int UW         = FRAC_BITS + 1;           // one minus fraction
  localparam int WW         = 2 * UW;                  // bilinear weight
  localparam int MW         = WW + COLOR_W;            // weighted channel
  localparam int SUMW       = MW + 2;
  localparam logic [SUMW-1:0] HALF_LSB = SUMW'(1) << (2 * FRAC_BITS - 1);
  localparam logic [UW-1:0]   UNIT     = UW'(1) << FRAC_BITS;

  // configuration
  logic        [SIZE_W-1:0] width_r, height_r;
  logic signed [TRIG_W-1:0] cos_r, sin_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(256);
      height_r <= SIZE_W'(256);
      cos_r    <= TRIG_W'(16);
      sin_r    <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_WIDTH:  width_r  <= cfg_ch.data;
        CFG_HEIGHT: height_r <= cfg_ch.data;
        CFG_COS:    cos_r    <= cfg_ch.data[TRIG_W-1:0];
        CFG_SIN:    sin_r    <= cfg_ch.data[TRIG_W-1:0];
        default:    ;
      endcase
    end
  end

  logic [CW-1:0]   size_w, size_h;
  logic [CW-2:0]   cx, cy;

  always_comb begin
    if (width_r < SIZE_W'(2))               size_w = CW'(2);
    else if (32'(width_r) > MAX_WIDTH)      size_w = CW'(MAX_WIDTH);
    else                                    size_w = width_r;
    if (height_r < SIZE_W'(2))              size_h = CW'(2);
    else if (32'(height_r) > MAX_HEIGHT)    size_h = CW'(MAX_HEIGHT);
    else                                    size_h = height_r;
  end

  assign cx = size_w[CW-1:1];
  assign cy = size_h[CW-1:1];

  function automatic logic [BAW-1:0] bank_addr(input logic [CW-1:0] row,
                                               input logic [CW-1:0] col);
    logic [31:0] full;
    full = 32'(row >> 1) * HALF_W + 32'(col >> 1);
    return full[BAW-1:0];
  endfunction

  // pipeline advance: everything moves unless a result waits unaccepted
  logic out_valid_r;
  logic adv;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage a: captured word
  logic                a_valid_r, a_op_r;
  logic [COORD_W-1:0]  a_x_r, a_y_r;
  logic [PIXEL_W-1:0]  a_pix_r;

  // stage b: rotation products
  logic                b_valid_r, b_op_r;
  logic [COORD_W-1:0]  b_x_r, b_y_r;
  logic [PIXEL_W-1:0]  b_pix_r;
  logic signed [PRW-1:0] b_xc_r, b_ys_r, b_yc_r, b_xs_r;

  // stage c: source position
  logic                c_valid_r, c_op_r;
  logic [COORD_W-1:0]  c_x_r, c_y_r;
  logic [PIXEL_W-1:0]  c_pix_r;
  logic signed [SW-1:0] c_sx_r, c_sy_r;

  // stage d: store read in flight, weights ready
  logic                d_valid_r, d_out_r;
  logic [COORD_W-1:0]  d_x_r, d_y_r;
  logic [1:0]          d_sel_r [4];
  logic [WW-1:0]       d_w_r [4];

  // stage e: weighted channels
  logic                e_valid_r, e_out_r;
  logic [COORD_W-1:0]  e_x_r, e_y_r;
  logic [MW-1:0]       e_prod_r [NUM_CH][4];

  // output register
  logic [COORD_W-1:0]  o_x_r, o_y_r;
  logic [COLOR_W-1:0]  o_col_r [NUM_CH];
  logic                o_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= in_ch.valid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r && (c_op_r == OP_COMPUTE);
      e_valid_r   <= d_valid_r;
      out_valid_r <= e_valid_r;
    end
  end

  // stage a
  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r  <= in_ch.operation;
      a_x_r   <= in_ch.pixel_x;
      a_y_r   <= in_ch.pixel_y;
      a_pix_r <= {in_ch.in_blue, in_ch.in_green, in_ch.in_red};
    end
  end

  // stage b
  logic signed [DW-1:0] dx, dy;
  assign dx = $signed(DW'(a_x_r)) - $signed(DW'(cx));
  assign dy = $signed(DW'(a_y_r)) - $signed(DW'(cy));

  always_ff @(posedge clk) begin
    if (adv) begin
      b_op_r  <= a_op_r;
      b_x_r   <= a_x_r;
      b_y_r   <= a_y_r;
      b_pix_r <= a_pix_r;
      b_xc_r  <= dx * cos_r;
      b_ys_r  <= dy * sin_r;
      b_yc_r  <= dy * cos_r;
      b_xs_r  <= dx * sin_r;
    end
  end

  // stage c
  logic signed [SW-1:0] cxf, cyf;
  assign cxf = $signed(SW'(cx) << FRAC_BITS);
  assign cyf = $signed(SW'(cy) << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (adv) begin
      c_op_r  <= b_op_r;
      c_x_r   <= b_x_r;
      c_y_r   <= b_y_r;
      c_pix_r <= b_pix_r;
      c_sx_r  <= SW'(b_xc_r) + SW'(b_ys_r) + cxf;
      c_sy_r  <= SW'(b_yc_r) - SW'(b_xs_r) + cyf;
    end
  end

  // stage d: neighbour coordinates, range check, bank addresses
  logic [IW-1:0]        ix, iy;
  logic [CW-1:0]        bx, by, nx, ny;
  logic [CW:0]          bx1, by1;
  logic [FRAC_BITS-1:0] wx, wy;
  logic [UW-1:0]        ux, uy;
  logic                 src_out;

  assign ix  = c_sx_r[SW-1:FRAC_BITS];
  assign iy  = c_sy_r[SW-1:FRAC_BITS];
  assign bx  = ix[CW-1:0];
  assign by  = iy[CW-1:0];
  assign bx1 = {1'b0, bx} + (CW+1)'(1);
  assign by1 = {1'b0, by} + (CW+1)'(1);
  assign nx  = (bx1 < {1'b0, size_w}) ? bx1[CW-1:0] : bx;
  assign ny  = (by1 < {1'b0, size_h}) ? by1[CW-1:0] : by;
  assign wx  = c_sx_r[FRAC_BITS-1:0];
  assign wy  = c_sy_r[FRAC_BITS-1:0];
  assign ux  = UNIT - UW'(wx);
  assign uy  = UNIT - UW'(wy);
  assign src_out = c_sx_r[SW-1] || c_sy_r[SW-1] ||
                   (ix >= IW'(size_w)) || (iy >= IW'(size_h));

  always_ff @(posedge clk) begin
    if (adv) begin
      d_x_r      <= c_x_r;
      d_y_r      <= c_y_r;
      d_out_r    <= src_out;
      d_sel_r[0] <= {by[0], bx[0]};
      d_sel_r[1] <= {by[0], nx[0]};
      d_sel_r[2] <= {ny[0], bx[0]};
      d_sel_r[3] <= {ny[0], nx[0]};
      d_w_r[0]   <= ux * uy;
      d_w_r[1]   <= WW'(wx) * WW'(uy);
      d_w_r[2]   <= WW'(ux) * WW'(wy);
      d_w_r[3]   <= WW'(wx) * WW'(wy);
    end
  end

  // banked image store, written and read in the same stage
  logic           wr_ok;
  logic [BAW-1:0] wr_addr;
  logic [1:0]     wr_bank;
  logic [PIXEL_W-1:0] bank_q [4];

  assign wr_ok   = adv && c_valid_r && (c_op_r == OP_WRITE) &&
                   (32'(c_x_r) < MAX_WIDTH) && (32'(c_y_r) < MAX_HEIGHT);
  assign wr_addr = bank_addr(CW'(c_y_r), CW'(c_x_r));
  assign wr_bank = {c_y_r[0], c_x_r[0]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [CW-1:0] col, row;
    assign col = (bx[0] == b[0]) ? bx : nx;
    assign row = (by[0] == b[1]) ? by : ny;

    irr_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk     (clk),
      .wr_en   (wr_ok && (wr_bank == 2'(b))),
      .wr_addr (wr_addr),
      .wr_data (c_pix_r),
      .rd_en   (adv),
      .rd_addr (bank_addr(row, col)),
      .rd_data (bank_q[b])
    );
  end

  // stage e: weight each neighbour
  always_ff @(posedge clk) begin
    if (adv) begin
      e_x_r   <= d_x_r;
      e_y_r   <= d_y_r;
      e_out_r <= d_out_r;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        for (int k = 0; k < 4; k++) begin
          e_prod_r[ch][k] <= MW'(d_w_r[k]) * MW'(bank_q[d_sel_r[k]][ch*COLOR_W +: COLOR_W]);
        end
      end
    end
  end

  // output stage: sum, round half up
  logic [SUMW-1:0] ch_sum [NUM_CH];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      ch_sum[ch] = SUMW'(e_prod_r[ch][0]) + SUMW'(e_prod_r[ch][1]) +
                   SUMW'(e_prod_r[ch][2]) + SUMW'(e_prod_r[ch][3]) + HALF_LSB;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_x_r   <= e_x_r;
      o_y_r   <= e_y_r;
      o_out_r <= e_out_r;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        o_col_r[ch] <= e_out_r ? '0 : COLOR_W'(ch_sum[ch] >> (2 * FRAC_BITS));
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.dest_x    = o_x_r;
  assign out_ch.dest_y    = o_y_r;
  assign out_ch.out_red   = o_col_r[0];
  assign out_ch.out_green = o_col_r[1];
  assign out_ch.out_blue  = o_col_r[2];
  assign out_ch.outside   = o_out_r;

  // a write word never reaches the blend stages
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && c_valid_r && (c_op_r == OP_WRITE)) |=> !d_valid_r)
    else $error("write word entered blend stages");

  // an outside result is black
  a_outside_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_out_r) |-> (o_col_r[0] == '0 && o_col_r[1] == '0 && o_col_r[2] == '0))
    else $error("outside result carries colour");

  // a stall keeps words in flight
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && e_valid_r) |=> e_valid_r)
    else $error("word lost during stall");

  // a new result comes only from the weighting stage
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(e_valid_r))
    else $error("result without word in flight");

endmodule
`default_nettype wire
